// ===== rtl/lshmb_pkg.sv =====
package lshmb_pkg;

   localparam int DimMax     = 128;
   localparam int FuncMax    = 8;
   localparam int DimW       = $clog2(DimMax);
   localparam int FuncW      = $clog2(FuncMax);
   localparam int StoreDepth = DimMax * FuncMax;
   localparam int AddrW      = $clog2(StoreDepth);

   // Configuration register indexes.
   localparam logic [1:0] RegShiftWidth  = 2'd0;
   localparam logic [1:0] RegHashCount   = 2'd1;
   localparam logic [1:0] RegDimsInUse   = 2'd2;
   localparam logic [1:0] RegBucketCount = 2'd3;

   localparam logic ActLoad  = 1'b0;
   localparam logic ActQuery = 1'b1;

endpackage

// ===== rtl/lsh_manhattan_bucket_hash_top.sv =====
// Locality-sensitive bucket hash.
// Input channel (req_*): one transaction per coordinate. action=0 stores a
// shift coordinate for one hash function; action=1 is a query coordinate.
// A query coordinate takes the quotient trunc(diff*S/(256*w)) for every hash
// function through one shared restoring divider (coordinate 0 also takes the
// seed); a load is stored while the block stays idle. On a query coordinate
// with last set, the block walks the stored quotients of the dimensions in
// use twice per active function (maximum pass, then polynomial pass with one
// 32x32 multiply-add per coordinate), then reduces the OR of the masked
// hashes modulo bucket_count with the same divider. req_stall is high while a
// transaction is at work or the result waits for the output register.
// Result channel (rsp_*): one bucket per query point, held in an output
// register until rsp_stall is low; the next request is taken meanwhile.
// Reset (synchronous, active high) restores the register defaults and clears
// the per-function seeds; shift and quotient stores are undefined until
// written. The user writes configuration through csr_* only while the block
// is idle; the block itself does not enforce it.
module lsh_manhattan_bucket_hash_top
   import lshmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [2:0]         req_func_index,
   input  logic [6:0]         req_coord_index,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_bucket,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_RDSH, S_DIFF, S_DIV, S_STQ, S_HINIT, S_MXRD, S_MXCMP,
      S_PRD, S_PMUL, S_PADD, S_FNEXT, S_MOD, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration.
   logic [15:0] width_ff;
   logic [3:0]  hcount_ff;
   logic [7:0]  dims_ff;
   logic [16:0] bcount_ff;

   // Stores.
   logic signed [31:0] shift_mem [StoreDepth];
   logic signed [31:0] quot_mem  [StoreDepth];
   logic signed [31:0] seed_ff   [FuncMax];
   logic signed [31:0] shift_rd_ff, quot_rd_ff;

   // Transaction registers.
   logic               last_ff;
   logic [DimW-1:0]    ci_ff;
   logic signed [31:0] val_ff;
   logic [FuncW-1:0]   f_ff;
   logic               pass_ff;   // 0: scale 100, 1: scale 1 seed
   logic [DimW:0]      i_ff;
   logic signed [32:0] mx_ff;
   logic [31:0]        h_ff, acc_ff;
   logic [31:0]        prod_ff;

   // Shared restoring divider: magnitude num / den, 40 steps per quotient.
   logic [39:0] num_ff;
   logic [39:0] rem_ff;
   logic [24:0] den_ff;
   logic        neg_ff;
   logic [5:0]  cnt_ff;
   logic [40:0] trial;
   logic [39:0] rem_sh;

   // Clamped configuration.
   logic [15:0] w_eff;
   logic [3:0]  k_eff;
   logic [7:0]  d_eff;
   logic [16:0] bc_eff;
   logic [31:0] mask;
   logic [AddrW-1:0] wr_addr, rd_addr;

   always_comb begin
      w_eff  = (width_ff == 16'd0) ? 16'd1 : width_ff;
      k_eff  = (hcount_ff < 4'd2) ? 4'd2 :
               (hcount_ff > 4'(FuncMax)) ? 4'(FuncMax) : hcount_ff;
      d_eff  = (dims_ff == 8'd0) ? 8'd1 :
               (dims_ff > 8'(DimMax)) ? 8'(DimMax) : dims_ff;
      bc_eff = (bcount_ff == 17'd0) ? 17'd1 :
               (bcount_ff > 17'd65536) ? 17'd65536 : bcount_ff;
      unique case (k_eff)
         4'd2:    mask = 32'h0000_FFFF;
         4'd3:    mask = 32'h0000_03FF;
         4'd4:    mask = 32'h0000_00FF;
         4'd5:    mask = 32'h0000_003F;
         4'd6:    mask = 32'h0000_001F;
         4'd7,
         4'd8:    mask = 32'h0000_000F;
         default: mask = 32'h0000_000F;
      endcase
      rem_sh  = {rem_ff[38:0], num_ff[39]};
      trial   = {1'b0, rem_sh} - {16'd0, den_ff};
      wr_addr = {f_ff, ci_ff};
      rd_addr = {f_ff, i_ff[DimW-1:0]};
   end

   assign req_stall = (state_ff != S_IDLE);

   // Memories.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && !req_stall && req_action == ActLoad)
         shift_mem[{req_func_index, req_coord_index}] <= req_value;
      if (state_ff == S_STQ && !pass_ff)
         quot_mem[wr_addr] <= 32'(neg_ff ? -num_ff : num_ff);
      shift_rd_ff <= shift_mem[wr_addr];
      quot_rd_ff  <= quot_mem[rd_addr];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= 16'd4500;
         hcount_ff <= 4'd4;
         dims_ff   <= 8'd128;
         bcount_ff <= 17'd1024;
         rsp_valid <= 1'b0;
         for (int j = 0; j < FuncMax; j++) seed_ff[j] <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               RegShiftWidth:  width_ff  <= csr_data[15:0];
               RegHashCount:   hcount_ff <= csr_data[3:0];
               RegDimsInUse:   dims_ff   <= csr_data[7:0];
               RegBucketCount: bcount_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall && state_ff != S_OUT) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall && req_action == ActQuery) begin
                  val_ff  <= req_value;
                  ci_ff   <= req_coord_index;
                  last_ff <= req_last;
                  f_ff    <= '0;
                  pass_ff <= 1'b0;
                  state_ff <= S_RDSH;
               end
            end
            // Index out of range cannot occur with 7-bit index and DimMax 128.
            S_RDSH: state_ff <= S_DIFF;
            S_DIFF: begin
               logic signed [32:0] diff;
               logic        [39:0] mag;
               diff = 33'(val_ff) - 33'(shift_rd_ff);
               mag  = diff[32] ? 40'(-diff) : 40'(diff);
               num_ff <= pass_ff ? mag : 40'(mag * 40'd100);
               neg_ff <= diff[32];
               den_ff <= {w_eff, 8'd0} + 25'd0;
               rem_ff <= '0;
               cnt_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!trial[40]) begin
                  rem_ff <= trial[39:0];
                  num_ff <= {num_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[38:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd39) state_ff <= S_STQ;
            end
            S_STQ: begin
               if (pass_ff)
                  seed_ff[f_ff] <= 32'(neg_ff ? -num_ff : num_ff);
               if (!pass_ff && ci_ff == '0) begin
                  pass_ff  <= 1'b1;
                  state_ff <= S_DIFF;
               end else begin
                  pass_ff <= 1'b0;
                  if (f_ff == FuncW'(FuncMax - 1)) begin
                     f_ff <= '0;
                     acc_ff <= '0;
                     state_ff <= last_ff ? S_HINIT : S_IDLE;
                  end else begin
                     f_ff <= f_ff + FuncW'(1);
                     state_ff <= S_RDSH;
                  end
               end
            end
            S_HINIT: begin
               mx_ff <= 33'(seed_ff[f_ff]);
               h_ff  <= '0;
               i_ff  <= '0;
               state_ff <= S_MXRD;
            end
            S_MXRD: state_ff <= S_MXCMP;
            S_MXCMP: begin
               if (33'(quot_rd_ff) > mx_ff) mx_ff <= 33'(quot_rd_ff);
               if (i_ff == (DimW+1)'(d_eff) - 1'b1) begin
                  i_ff <= '0;
                  state_ff <= S_PRD;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_MXRD;
               end
            end
            S_PRD: state_ff <= S_PMUL;
            S_PMUL: begin
               prod_ff <= h_ff * (mx_ff[31:0] + 32'd10);
               state_ff <= S_PADD;
            end
            S_PADD: begin
               h_ff <= prod_ff + quot_rd_ff;
               if (i_ff == (DimW+1)'(d_eff) - 1'b1) state_ff <= S_FNEXT;
               else begin
                  i_ff <= i_ff + 1'b1;
                  state_ff <= S_PRD;
               end
            end
            S_FNEXT: begin
               acc_ff <= acc_ff | (h_ff & mask);
               if ({1'b0, f_ff} == 4'(k_eff - 4'd1)) begin
                  num_ff <= {(acc_ff | (h_ff & mask)), 8'd0};
                  den_ff <= 25'(bc_eff);
                  rem_ff <= '0;
                  cnt_ff <= 6'd8;
                  state_ff <= S_MOD;
               end else begin
                  f_ff <= f_ff + FuncW'(1);
                  state_ff <= S_HINIT;
               end
            end
            S_MOD: begin
               if (!trial[40]) rem_ff <= trial[39:0];
               else rem_ff <= rem_sh;
               num_ff <= {num_ff[38:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd39) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid || !rsp_stall) begin
                  rsp_bucket <= rem_ff[15:0];
                  rsp_valid  <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A result is only raised from the output state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");
   // A held result does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bucket))
      else $error("result changed while stalled");
   // Requests are only taken when idle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request taken while busy");

endmodule

// ===== dv/tb_lsh_manhattan_bucket_hash_top.sv =====
`timescale 1ns / 1ps

module tb_lsh_manhattan_bucket_hash_top
   import lshmb_pkg::*;
();

   localparam int StallLimit = 60000;
   localparam int SettleCycles = 1200;

   // Scoreboard: mirrors the hash state and holds the expected buckets.
   class bucket_scoreboard;
      int unsigned width_reg, hash_reg, dims_reg, buckets_reg;
      int shifts[StoreDepth];
      int quotients[StoreDepth];
      int seeds[FuncMax];
      bit [15:0] expected_buckets[$];
      int errors;

      function void clear_state();
         width_reg = 4500;
         hash_reg = 4;
         dims_reg = 128;
         buckets_reg = 1024;
         foreach (seeds[f]) seeds[f] = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [16:0] data);
         case (idx)
            RegShiftWidth: begin
               width_reg = data[15:0];
            end
            RegHashCount: begin
               hash_reg = data[3:0];
            end
            RegDimsInUse: begin
               dims_reg = data[7:0];
            end
            default: begin
               buckets_reg = data;
            end
         endcase
      endfunction

      function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Notes one accepted transaction and predicts its bucket, if any.
      function void note_input(logic act, logic [2:0] fi, logic [6:0] ci,
                               logic signed [31:0] v, logic lst);
         longint divisor, diff, mx;
         int unsigned k, d, bc;
         bit [31:0] mask, acc, h, m;
         if (act == ActLoad) begin
            shifts[fi * DimMax + ci] = v;
            return;
         end
         divisor = 256 * longint'(sat(width_reg, 1, 65535));
         for (int f = 0; f < FuncMax; f++) begin
            diff = longint'(v) - longint'(shifts[f * DimMax + ci]);
            quotients[f * DimMax + ci] = int'((diff * 100) / divisor);
            if (ci == 0) seeds[f] = int'(diff / divisor);
         end
         if (!lst) return;
         k = sat(hash_reg, 2, FuncMax);
         d = sat(dims_reg, 1, DimMax);
         bc = sat(buckets_reg, 1, 65536);
         mask = (32'd1 << (32 / k)) - 32'd1;
         acc = 0;
         for (int f = 0; f < k; f++) begin
            mx = seeds[f];
            for (int i = 0; i < d; i++)
               if (quotients[f * DimMax + i] > mx) mx = quotients[f * DimMax + i];
            m = 32'(mx + 10);
            h = 0;
            for (int i = 0; i < d; i++)
               h = h * m + 32'(quotients[f * DimMax + i]);
            acc |= h & mask;
         end
         expected_buckets = {expected_buckets, 16'(longint'(acc) % bc)};
      endfunction

      // Compares one received bucket with the oldest expectation.
      function void check_result(logic [15:0] bucket);
         bit [15:0] want;
         if (expected_buckets.size() == 0) begin
            $error("bucket: no result expected, actual %0d", bucket);
            errors++;
            return;
         end
         want = expected_buckets.pop_front();
         if (bucket !== want) begin
            $error("bucket: expected %0d, actual %0d", want, bucket);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_action = 0;
   logic [2:0]         req_func_index = 0;
   logic [6:0]         req_coord_index = 0;
   logic signed [31:0] req_value = 0;
   logic               req_last = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [15:0]        rsp_bucket;
   logic               csr_write = 0;
   logic [1:0]         csr_index = 0;
   logic [16:0]        csr_data = 0;

   bucket_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   int dims_now = 128;

   lsh_manhattan_bucket_hash_top dut (.*);

   always #2 clock = ~clock;

   // Result side: checks each result, stalls at random, runs the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_bucket);
            quiet_cycles = 0;
         end else if (!(req_valid && !req_stall)) begin
            quiet_cycles++;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Offers one transaction and waits until it is accepted.
   task automatic send(logic act, logic [2:0] fi, logic [6:0] ci,
                       logic signed [31:0] v, logic lst);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_func_index <= fi;
      req_coord_index <= ci;
      req_value <= v;
      req_last <= lst;
      do @(posedge clock); while (req_stall);
      sb.note_input(act, fi, ci, v, lst);
      quiet_cycles = 0;
   endtask

   // Drives one register write; the caller drops the write enable afterwards.
   task automatic write_reg(logic [1:0] idx, logic [16:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Lets every pending result arrive and the last query finish its work.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_buckets.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3, 4: return $urandom;
         default: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
      endcase
   endfunction

   // Mostly well-formed points with random content, some loads and strays.
   task automatic random_items(int count);
      int pos;
      int sel;
      logic [6:0] ci;
      logic lst;
      pos = 0;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            send(ActLoad, 3'($urandom), 7'($urandom), pick_value(), 1'($urandom));
         end else begin
            ci = (sel < 25) ? 7'($urandom) : 7'(pos);
            lst = (pos == dims_now - 1) || ($urandom_range(0, 99) < 8);
            send(ActQuery, 3'($urandom), ci, pick_value(), lst);
            pos = lst ? 0 : pos + 1;
         end
      end
   endtask

   task automatic run_phase(int w, int k, int d, int bc, int count);
      write_reg(RegShiftWidth, 17'(w));
      write_reg(RegHashCount, 17'(k));
      write_reg(RegDimsInUse, 17'(d));
      write_reg(RegBucketCount, 17'(bc));
      csr_write <= 1'b0;
      dims_now = (d[7:0] == 0) ? 1 : ((d[7:0] > DimMax) ? DimMax : d[7:0]);
      random_items(count);
      drain();
   endtask

   initial begin
      sb.clear_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 58;

      // Every shift coordinate is written before any query reads it.
      for (int f = 0; f < FuncMax; f++)
         for (int i = 0; i < DimMax; i++)
            send(ActLoad, 3'(f), 7'(i), pick_value(), 1'($urandom));

      // One full point at reset settings so that every quotient is written.
      for (int i = 0; i < DimMax; i++)
         send(ActQuery, 3'($urandom), 7'(i),
              (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000, i == DimMax - 1);
      send(ActQuery, 3'd7, 7'd0, 32'sd0, 1'b1);
      send(ActQuery, 3'd0, 7'd127, 32'sd256, 1'b1);
      drain();

      // Saturated and extreme register settings.
      run_phase(0, 2, 1, 0, 30);
      run_phase(65535, 8, 128, 65536, 40);
      run_phase(1, 15, 200, 131071, 40);

      send_idle_pct = 58;
      recv_idle_pct = 32;
      run_phase(37, 3, 5, 1000, 80);
      // The result side holds off while short points keep coming.
      hold_cycles = 4000;
      run_phase(4500, 1, 0, 97, 60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(300, 5, 12, 4096, 120);
      run_phase(12345, 7, 64, 65535, 60);

      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
